FILE: rtl/ils_pkg.sv
// shared types and codes of the indexed list store
package ils_pkg;

    // request codes
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_REPLACE = 3'd2;
    localparam logic [2:0] OP_INSERT  = 3'd3;
    localparam logic [2:0] OP_DELETE  = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef logic [63:0] t_word;
    typedef logic [8:0]  t_len;

    // request transaction
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] position;
        t_word      word_in;
        logic       has_value;
    } t_req;

    // result transaction
    typedef struct packed {
        logic [1:0] status;
        t_word      word_out;
        t_len       length;
    } t_rsp;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_DRAIN,
        S_FILL,
        S_READ
    } t_state;

    // memory port controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_from_mem;
    } t_mem_ctl;

    // result controls from the sequencer
    typedef struct packed {
        logic       done;
        logic [1:0] status;
        logic       with_word;
    } t_rsp_ctl;

endpackage

FILE: rtl/ils_seq.sv
// sequencer: request decode, length count and shift address walk
module ils_seq #(
    parameter int CAPACITY = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [2:0]                     i_op,
    input  logic [7:0]                     i_pos,
    input  logic                           i_has,
    output ils_pkg::t_mem_ctl              o_mem,
    output logic [$clog2(CAPACITY)-1:0]    o_raddr,
    output logic [$clog2(CAPACITY)-1:0]    o_waddr,
    output ils_pkg::t_rsp_ctl              o_rsp,
    output logic [$clog2(CAPACITY+1)-1:0]  o_count_nxt,
    output logic                           o_busy
);
    import ils_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_src, n_src;
    logic [AW-1:0]   r_dst, n_dst;
    logic            r_wpend, n_wpend;

    logic            in_range;
    logic            full;
    logic            is_ins;
    logic            src_last;
    logic [AW-1:0]   pos_a;
    logic [AW-1:0]   top_a;

    // request checks against the current length
    assign in_range = PW'(i_pos) < PW'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign is_ins   = (i_op == OP_INSERT);
    assign pos_a    = AW'(i_pos);
    assign top_a    = AW'(r_count - CW'(1));
    assign src_last = is_ins ? (r_src == pos_a) : (r_src == top_a);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (in_range) begin
                    if (i_op == OP_READ) begin
                        n_state = S_READ;
                    end else if (is_ins && !full) begin
                        n_state = S_SHIFT;
                    end else if (i_op == OP_DELETE && pos_a != top_a) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (src_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = is_ins ? S_FILL : S_IDLE;
            end
            S_FILL:  n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        o_mem     = '0;
        o_raddr   = r_src;
        o_waddr   = r_dst;
        o_rsp     = '0;
        n_count   = r_count;
        n_src     = r_src;
        n_dst     = r_dst;
        n_wpend   = r_wpend;
        case (r_state)
            S_EXEC: begin
                o_rsp.done   = 1'b1;
                o_rsp.status = ST_OK;
                case (i_op)
                    OP_PUSH: begin
                        if (!i_has) begin
                            o_rsp.status = ST_MISSING;
                        end else if (full) begin
                            o_rsp.status = ST_FULL;
                        end else begin
                            o_mem.wr_en = 1'b1;
                            o_waddr     = AW'(r_count);
                            n_count     = r_count + CW'(1);
                        end
                    end
                    OP_POP: begin
                        if (r_count != '0) n_count = r_count - CW'(1);
                    end
                    OP_REPLACE: begin
                        if (!in_range) begin
                            o_rsp.status = ST_RANGE;
                        end else begin
                            o_mem.wr_en = 1'b1;
                            o_waddr     = pos_a;
                        end
                    end
                    OP_INSERT: begin
                        if (!in_range) begin
                            o_rsp.status = ST_RANGE;
                        end else if (full) begin
                            o_rsp.status = ST_FULL;
                        end else begin
                            o_rsp.done = 1'b0;
                            n_src      = top_a;
                            n_wpend    = 1'b0;
                        end
                    end
                    OP_DELETE: begin
                        if (!in_range) begin
                            o_rsp.status = ST_RANGE;
                        end else if (pos_a == top_a) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            o_rsp.done = 1'b0;
                            n_src      = pos_a + AW'(1);
                            n_wpend    = 1'b0;
                        end
                    end
                    OP_READ: begin
                        if (!in_range) begin
                            o_rsp.status = ST_RANGE;
                        end else begin
                            o_rsp.done  = 1'b0;
                            o_mem.rd_en = 1'b1;
                            o_raddr     = pos_a;
                        end
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                // read one entry, write back the one read last cycle
                o_mem.rd_en       = 1'b1;
                o_mem.wr_en       = r_wpend;
                o_mem.wr_from_mem = 1'b1;
                n_wpend           = 1'b1;
                n_dst             = is_ins ? r_src + AW'(1) : r_src - AW'(1);
                if (!src_last) begin
                    n_src = is_ins ? r_src - AW'(1) : r_src + AW'(1);
                end
            end
            S_DRAIN: begin
                o_mem.wr_en       = 1'b1;
                o_mem.wr_from_mem = 1'b1;
                if (!is_ins) begin
                    o_rsp.done = 1'b1;
                    n_count    = r_count - CW'(1);
                end
            end
            S_FILL: begin
                o_mem.wr_en = 1'b1;
                o_waddr     = pos_a;
                o_rsp.done  = 1'b1;
                n_count     = r_count + CW'(1);
            end
            S_READ: begin
                o_rsp.done      = 1'b1;
                o_rsp.with_word = 1'b1;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wpend <= n_wpend;
        end
    end

    // address counters
    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_dst <= n_dst;
    end

    assign o_count_nxt = n_count;
    assign o_busy      = (r_state != S_IDLE);

endmodule

FILE: rtl/indexed_list_store.sv
// top level of the indexed list store: entry memory, request and result registers
//
//  channel   ports                      transaction
//  request   start, busy, i_req         accepted when start high and busy low
//  result    o_done, o_rsp              one cycle strobe, always taken
//
// push, pop, replace, errors and delete of the last entry end in the exec state;
// read adds a read state; insert and any other delete shift entries one per cycle
// through the single read and single write port, then drain, and insert then fills
// its position. the result strobe is high in the first cycle with busy low. reset
// clears the length and the control state only; entry contents are unknown until
// written. results cannot be held off.
module indexed_list_store #(
    parameter int CAPACITY  = 256,
    parameter int WORD_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  ils_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output ils_pkg::t_rsp o_rsp
);
    import ils_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [WORD_BITS-1:0] r_mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WORD_BITS-1:0] r_word;
    logic [2:0]           r_op;
    logic [7:0]           r_pos;
    logic                 r_has;
    logic                 r_done;
    t_rsp                 r_rsp;

    t_mem_ctl             mem_ctl;
    t_rsp_ctl             rsp_ctl;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [CW-1:0]        count_nxt;
    logic [WORD_BITS-1:0] wdata;
    logic                 accept;

    assign accept = start && !busy;

    // capture the request transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.opcode;
            r_pos  <= i_req.position;
            r_has  <= i_req.has_value;
            r_word <= i_req.has_value ? i_req.word_in[WORD_BITS-1:0] : '0;
        end
    end

    ils_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (r_op),
        .i_pos       (r_pos),
        .i_has       (r_has),
        .o_mem       (mem_ctl),
        .o_raddr     (raddr),
        .o_waddr     (waddr),
        .o_rsp       (rsp_ctl),
        .o_count_nxt (count_nxt),
        .o_busy      (busy)
    );

    // write data: request word or entry read in the previous cycle
    assign wdata = mem_ctl.wr_from_mem ? r_rdata : r_word;

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_ctl.wr_en) r_mem[waddr] <= wdata;
        if (mem_ctl.rd_en) r_rdata <= r_mem[raddr];
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rsp_ctl.done;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (rsp_ctl.done) begin
            r_rsp.status   <= rsp_ctl.status;
            r_rsp.word_out <= rsp_ctl.with_word ? t_word'(r_rdata) : '0;
            r_rsp.length   <= t_len'(count_nxt);
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

FILE: verif/ils_checker.sv
// result checker for the indexed list store: predicts every transaction and compares
`timescale 1ns / 100ps
module ils_checker #(
    parameter int CAPACITY = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  ils_pkg::t_req  i_req,
    input  logic           i_done,
    input  ils_pkg::t_rsp  i_rsp,
    output int             o_fail_count,
    output int             o_pending,
    output ils_pkg::t_len  o_list_len
);

    import ils_pkg::*;

    // shadow copy of the list
    t_word list_words [CAPACITY];
    t_len  list_len = '0;

    t_rsp  expected_rsp_q [$];
    t_rsp  want;
    t_rsp  got;
    int    fail_total = 0;

    // apply one request to the shadow list and work out its result
    task automatic apply_list_op(input t_req rq, output t_rsp rs);
        t_word val;
        int    pos;
        val = rq.has_value ? rq.word_in : '0;
        pos = int'(rq.position);
        rs = '0;
        rs.status = ST_OK;
        case (rq.opcode)
            OP_PUSH: begin
                if (!rq.has_value) begin
                    rs.status = ST_MISSING;
                end else if (list_len >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                end
            end
            OP_POP: begin
                if (list_len != 0) list_len--;
            end
            OP_REPLACE: begin
                if (pos >= list_len) rs.status = ST_RANGE;
                else list_words[pos] = val;
            end
            OP_INSERT: begin
                if (pos >= list_len) begin
                    rs.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    for (int i = int'(list_len); i > pos; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos >= list_len) begin
                    rs.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            OP_READ: begin
                if (pos >= list_len) rs.status = ST_RANGE;
                else rs.word_out = list_words[pos];
            end
            default: begin
                // spare opcodes leave everything alone
            end
        endcase
        rs.length = list_len;
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = '0;
            expected_rsp_q.delete();
        end else begin
            // a finished transaction against the oldest prediction
            if (i_done !== 1'b0) begin
                if (expected_rsp_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("unexpected result: status %0d word %h length %0d",
                                 i_rsp.status, i_rsp.word_out, i_rsp.length);
                    fail_total++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_done !== 1'b1 || i_rsp.status !== want.status ||
                        i_rsp.word_out !== want.word_out || i_rsp.length !== want.length) begin
                        if (fail_total < 10)
                            $display({"mismatch: status exp %0d got %0d, word exp %h got %h,",
                                      " length exp %0d got %0d"},
                                     want.status, i_rsp.status, want.word_out,
                                     i_rsp.word_out, want.length, i_rsp.length);
                        fail_total++;
                    end
                end
            end
            // an accepted request
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                apply_list_op(i_req, got);
                expected_rsp_q.push_back(got);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_rsp_q.size();
        o_list_len   <= list_len;
    end

endmodule

FILE: verif/tb_top.sv
// testbench top for the indexed list store: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_top;

    import ils_pkg::*;

    localparam int LIST_CAP = 256;
    localparam int DRAIN_LIMIT = 4000;

    // opcodes the block must ignore
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam t_word ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_word PAT_5    = 64'h5555_5555_5555_5555;
    localparam t_word PAT_A    = 64'hAAAA_AAAA_AAAA_AAAA;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_req req   = '0;
    logic busy;
    logic done;
    t_rsp rsp;

    int   fail_count;
    int   pending;
    t_len list_len;
    int   burst_left = 0;
    bit   drained;

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    indexed_list_store #(
        .CAPACITY (LIST_CAP),
        .WORD_BITS(64)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .start  (start),
        .i_req  (req),
        .busy   (busy),
        .o_done (done),
        .o_rsp  (rsp)
    );

    ils_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (req),
        .i_done      (done),
        .i_rsp       (rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_len  (list_len)
    );

    function automatic t_req make_req(input logic [2:0] op, input logic [7:0] pos,
                                      input t_word word, input logic has);
        t_req r;
        r.opcode    = op;
        r.position  = pos;
        r.word_in   = word;
        r.has_value = has;
        return r;
    endfunction

    // mostly inside the list, sometimes just past its end, sometimes anywhere
    function automatic logic [7:0] pick_pos(input t_len len);
        int r;
        r = $urandom_range(99);
        if (len != 0 && r < 75) return 8'($urandom_range(int'(len) - 1, 0));
        if (r < 85 && len < LIST_CAP) return len[7:0];
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic t_word pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 8) return '0;
        if (r < 16) return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // present one transaction, idling between bursts, and wait for acceptance
    task automatic issue(input t_req r);
        int gap;
        int r_gap;
        if (burst_left == 0) begin
            r_gap = $urandom_range(99);
            if (r_gap < 70) gap = $urandom_range(4, 1);
            else if (r_gap < 95) gap = $urandom_range(30, 5);
            else gap = $urandom_range(300, 100);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(9) == 0) ? 48 : $urandom_range(16, 1);
        end
        burst_left--;
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy !== 1'b0);
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained(output bit ok);
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        ok = (pending == 0);
    endtask

    // random mix of requests that keeps the list near len_cap entries or below
    task automatic random_items(input int n, input int len_cap);
        int         push_w;
        int         r;
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            push_w = (list_len >= len_cap) ? 5 : ((list_len < 4) ? 45 : 22);
            r = $urandom_range(99);
            if (r < push_w) begin
                op = OP_PUSH;
            end else begin
                r = $urandom_range(99);
                if (r < 12) op = OP_POP;
                else if (r < 30) op = OP_REPLACE;
                else if (r < 50) op = (list_len >= len_cap) ? OP_DELETE : OP_INSERT;
                else if (r < 72) op = OP_DELETE;
                else if (r < 95) op = OP_READ;
                else op = r[0] ? OP_SPARE7 : OP_SPARE6;
            end
            issue(make_req(op, pick_pos(list_len), pick_word(), $urandom_range(99) < 90));
        end
    endtask

    // run limit
    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // stimulus and verdict
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        issue(make_req(OP_READ,    8'd0, ALL_ONES, 1'b1));
        issue(make_req(OP_POP,     8'd0, '0, 1'b0));
        issue(make_req(OP_REPLACE, 8'd0, PAT_5, 1'b1));
        issue(make_req(OP_INSERT,  8'd0, PAT_A, 1'b1));
        issue(make_req(OP_DELETE,  8'd0, '0, 1'b0));
        issue(make_req(OP_PUSH,    8'd0, ALL_ONES, 1'b0));
        // build a short list of extreme words
        issue(make_req(OP_PUSH,    8'd255, '0, 1'b1));
        issue(make_req(OP_PUSH,    8'd0, ALL_ONES, 1'b1));
        issue(make_req(OP_PUSH,    8'd0, PAT_5, 1'b1));
        issue(make_req(OP_PUSH,    8'd0, PAT_A, 1'b1));
        issue(make_req(OP_READ,    8'd0, '0, 1'b0));
        issue(make_req(OP_READ,    8'd3, '0, 1'b0));
        issue(make_req(OP_READ,    8'd4, '0, 1'b0));
        issue(make_req(OP_READ,    8'd255, '0, 1'b0));
        // replace with and without a value
        issue(make_req(OP_REPLACE, 8'd1, 64'h0123_4567_89AB_CDEF, 1'b1));
        issue(make_req(OP_REPLACE, 8'd2, ALL_ONES, 1'b0));
        issue(make_req(OP_READ,    8'd2, '0, 1'b0));
        // insert at the head and at the last index, delete at the head and just past the end
        issue(make_req(OP_INSERT,  8'd0, 64'hFEDC_BA98_7654_3210, 1'b1));
        issue(make_req(OP_INSERT,  8'd4, ALL_ONES, 1'b0));
        issue(make_req(OP_DELETE,  8'd0, '0, 1'b0));
        issue(make_req(OP_DELETE,  8'd5, '0, 1'b0));
        // spare opcodes are ignored
        issue(make_req(OP_SPARE6,  8'd1, ALL_ONES, 1'b1));
        issue(make_req(OP_SPARE7,  8'd255, PAT_5, 1'b0));
        issue(make_req(OP_READ,    8'd1, '0, 1'b0));
        issue(make_req(OP_POP,     8'd0, '0, 1'b0));

        // short lists, random content
        random_items(120, 24);

        // let everything settle, then fill the store to capacity
        wait_drained(drained);
        repeat (LIST_CAP - int'(list_len))
            issue(make_req(OP_PUSH, pick_pos(list_len), pick_word(), 1'b1));

        // full store boundaries
        issue(make_req(OP_PUSH,    8'd0, PAT_5, 1'b1));
        issue(make_req(OP_PUSH,    8'd0, PAT_5, 1'b0));
        issue(make_req(OP_INSERT,  8'd0, PAT_A, 1'b1));
        issue(make_req(OP_INSERT,  8'd255, PAT_A, 1'b1));
        issue(make_req(OP_READ,    8'd255, '0, 1'b0));
        issue(make_req(OP_REPLACE, 8'd255, ALL_ONES, 1'b1));
        issue(make_req(OP_READ,    8'd255, '0, 1'b0));
        issue(make_req(OP_DELETE,  8'd0, '0, 1'b0));
        issue(make_req(OP_INSERT,  8'd0, 64'h8000_0000_0000_0001, 1'b1));
        issue(make_req(OP_READ,    8'd0, '0, 1'b0));
        issue(make_req(OP_DELETE,  8'd255, '0, 1'b0));
        issue(make_req(OP_PUSH,    8'd0, pick_word(), 1'b1));
        random_items(30, LIST_CAP);

        // shrink back with pops and scattered deletes
        while (list_len > 12) begin
            if ($urandom_range(3) == 0)
                issue(make_req(OP_DELETE, pick_pos(list_len), pick_word(), 1'b0));
            else
                issue(make_req(OP_POP, pick_pos(list_len), pick_word(),
                               1'($urandom_range(1))));
        end

        // more short lists
        random_items(150, 16);

        // drain, then watch for stray results
        wait_drained(drained);
        if (drained) repeat (LIST_CAP + 8) @(posedge clk);
        if (drained && fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
